[design/ffba_pkg.sv]
package ffba_pkg;

    localparam int unsigned BLOCK_BYTES_DEF   = 64;
    localparam int unsigned HEAP_BLOCKS_DEF   = 1024;
    localparam int unsigned HEADER_BYTES_DEF  = 16;
    localparam int unsigned MAX_FRAGMENTS_DEF = 64;

    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

[design/ffba_cell.sv]
module ffba_cell #(
    parameter int unsigned ENT_W = 26
) (
    input  logic             clk,
    input  logic             shift,
    input  logic [ENT_W-1:0] d,
    output logic [ENT_W-1:0] q
);

    logic [ENT_W-1:0] entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

[design/ffba_div.sv]
module ffba_div #(
    parameter int unsigned NUM_W   = 25,
    parameter int unsigned DIVISOR = ffba_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned QUO_SAT = ffba_pkg::HEAP_BLOCKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    // quotients above QUO_SAT all report as QUO_SAT + 1; below that the
    // reciprocal multiply is exact for every dividend under LIMIT
    localparam longint unsigned LIMIT = (64'(QUO_SAT) + 64'd1) * 64'(DIVISOR);
    localparam int unsigned X_W   = $clog2(LIMIT);
    localparam int unsigned D_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam int unsigned SHIFT = X_W + D_W;
    localparam int unsigned R_W   = X_W + 2;
    localparam int unsigned P_W   = X_W + R_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                      / 64'(DIVISOR);

    logic             busy_reg;
    logic             done_reg;
    logic             over_reg;
    logic [X_W-1:0]   num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [P_W-1:0]   product;

    assign product = P_W'(num_reg) * P_W'(R_W'(RECIP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= X_W'(dividend);
            over_reg <= 64'(dividend) >= LIMIT;
        end
        if (busy_reg)
        begin
            quo_reg <= over_reg ? NUM_W'(QUO_SAT + 1) : NUM_W'(product[P_W-1:SHIFT]);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/first_fit_block_allocator_top.sv]
// First-fit block allocator over a heap of HEAP_BLOCKS blocks of BLOCK_BYTES bytes.
// Input channel s_*: one beat is one request. s_tuser[0] is the opcode (0 allocate,
// 1 free), s_tuser[1] marks the size as bytes (header added, rounded up to blocks).
// Output channel m_*: one beat per request, status and payload byte offset.
// The used-fragment table lives in a chain of MAX_FRAGMENTS cells that rotates one
// full turn per request; the controller reads the head cell and feeds the tail,
// inserting or dropping an entry on the way.
// After the accepting edge a request passes a setup state, the table turn and an
// output load before m_tvalid rises. A beat with the bytes flag set first passes
// the divide by BLOCK_BYTES, a registered reciprocal multiply.
// One request is in work at a time; s_tready returns the cycle after the result
// loads, so a new request is never taken before the last one is through.
// s_tready is high whenever no request is in work, also while a result waits.
// A stalled m_tready holds the result; a finished request then waits to load it.
// Reset empties the table (fragment count zero) and drops any pending result;
// no clearing pass is needed.
module first_fit_block_allocator_top #(
    parameter int unsigned BLOCK_BYTES   = ffba_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned HEAP_BLOCKS   = ffba_pkg::HEAP_BLOCKS_DEF,
    parameter int unsigned HEADER_BYTES  = ffba_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_FRAGMENTS = ffba_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,  // request_size, free_offset
    input  logic [ffba_pkg::S_TUSER_W-1:0]   s_tuser,  // opcode, size_in_bytes
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata   // status, payload_offset, zero fill
);

    localparam int unsigned ADDR_W = $clog2(HEAP_BLOCKS);
    localparam int unsigned LEN_W  = $clog2(HEAP_BLOCKS + 1);
    localparam int unsigned ENT_W  = LEN_W + ADDR_W;
    localparam int unsigned CNT_W  = $clog2(MAX_FRAGMENTS + 1);
    localparam int unsigned NUM_W  = $clog2((2**ffba_pkg::SIZE_W) + HEADER_BYTES + BLOCK_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] M_SCAN = 2'd0;
    localparam logic [1:0] M_INS  = 2'd1;
    localparam logic [1:0] M_DEL  = 2'd2;
    localparam logic [1:0] M_PASS = 2'd3;

    function automatic logic [ffba_pkg::OFFSET_W-1:0] pay16(input logic [ADDR_W-1:0] s);
        logic [31:0] p;
        p = 32'(s) * 32'(BLOCK_BYTES) + 32'(HEADER_BYTES);
        return p[ffba_pkg::OFFSET_W-1:0];
    endfunction

    logic [2:0]                      state_reg;
    logic [1:0]                      mode_reg;
    logic [CNT_W-1:0]                step_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            op_reg;
    logic                            bytes_reg;
    logic [ffba_pkg::SIZE_W-1:0]     size_reg;
    logic [ffba_pkg::OFFSET_W-1:0]   off_reg;
    logic [LEN_W-1:0]                blk_reg;
    logic [LEN_W-1:0]                prev_end_reg;
    logic [ENT_W-1:0]                hold_reg;
    logic [ffba_pkg::STATUS_W-1:0]   status_reg;
    logic [ffba_pkg::OFFSET_W-1:0]   res_off_reg;
    logic                            m_valid_reg;
    logic [ffba_pkg::M_TDATA_W-1:0]  m_data_reg;

    ffba_pkg::div_ctl_t              div_ctl;
    logic [NUM_W-1:0]                div_quo;
    logic [NUM_W-1:0]                div_num;

    logic [ENT_W-1:0]                cell_q [MAX_FRAGMENTS];
    logic [ENT_W-1:0]                push;
    logic                            shift;

    logic                            s_fire;
    logic                            last_step;
    logic [ADDR_W-1:0]               h_start;
    logic [LEN_W-1:0]                h_start_ext;
    logic [LEN_W-1:0]                h_len;
    logic                            in_table;
    logic                            at_end;
    logic                            gap_fits;
    logic                            end_fits;
    logic                            off_match;
    logic [ENT_W-1:0]                new_ent;
    logic [NUM_W-1:0]                raw_blk;
    logic [NUM_W-1:0]                req_blk;
    logic                            out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign div_num       = NUM_W'(s_tdata[ffba_pkg::SIZE_W-1:0])
                         + NUM_W'(HEADER_BYTES + BLOCK_BYTES - 1);
    assign div_ctl.start = s_fire && s_tuser[1];

    ffba_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (BLOCK_BYTES),
        .QUO_SAT (HEAP_BLOCKS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (div_num),
        .done     (div_ctl.done),
        .quotient (div_quo)
    );

    assign shift = (state_reg == S_ROT);

    for (genvar i = 0; i < MAX_FRAGMENTS; i++)
    begin : g_cell
        logic [ENT_W-1:0] cell_d;
        if (i == MAX_FRAGMENTS - 1)
        begin : g_tail
            assign cell_d = push;
        end
        else
        begin : g_mid
            assign cell_d = cell_q[i+1];
        end
        ffba_cell #(
            .ENT_W (ENT_W)
        ) u_cell (
            .clk   (clk),
            .shift (shift),
            .d     (cell_d),
            .q     (cell_q[i])
        );
    end

    assign h_start     = cell_q[0][ADDR_W-1:0];
    assign h_len       = cell_q[0][ENT_W-1:ADDR_W];
    assign h_start_ext = LEN_W'(h_start);
    assign in_table    = step_reg < cnt_reg;
    assign at_end      = step_reg == cnt_reg;
    assign last_step   = step_reg == CNT_W'(MAX_FRAGMENTS - 1);
    assign gap_fits    = (h_start_ext >= prev_end_reg)
                      && ((h_start_ext - prev_end_reg) >= blk_reg);
    assign end_fits    = (prev_end_reg <= LEN_W'(HEAP_BLOCKS))
                      && ((LEN_W'(HEAP_BLOCKS) - prev_end_reg) >= blk_reg);
    assign off_match   = pay16(h_start) == off_reg;
    assign new_ent     = {blk_reg, prev_end_reg[ADDR_W-1:0]};

    assign raw_blk = bytes_reg ? div_quo : NUM_W'(size_reg);
    assign req_blk = (raw_blk == '0) ? NUM_W'(1) : raw_blk;

    always_comb
    begin
        push = cell_q[0];
        unique case (mode_reg)
            M_SCAN:
            begin
                if (op_reg == ffba_pkg::OP_ALLOC)
                begin
                    if ((in_table && gap_fits) || (at_end && end_fits))
                    begin
                        push = new_ent;
                    end
                end
                else if (in_table && off_match)
                begin
                    push = cell_q[1];
                end
            end
            M_INS:  push = hold_reg;
            M_DEL:  push = cell_q[1];
            M_PASS: push = cell_q[0];
            default: push = cell_q[0];
        endcase
    end

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= M_SCAN;
            step_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        state_reg <= s_tuser[1] ? S_DIV : S_PREP;
                    end
                end
                S_DIV:
                begin
                    if (div_ctl.done)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ROT;
                    mode_reg  <= M_SCAN;
                    if (op_reg == ffba_pkg::OP_ALLOC)
                    begin
                        if (req_blk > NUM_W'(HEAP_BLOCKS) || cnt_reg >= CNT_W'(MAX_FRAGMENTS))
                        begin
                            mode_reg <= M_PASS;
                        end
                    end
                end
                S_ROT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (mode_reg == M_SCAN)
                    begin
                        if (op_reg == ffba_pkg::OP_ALLOC)
                        begin
                            if ((in_table && gap_fits) || (at_end && end_fits))
                            begin
                                mode_reg <= M_INS;
                            end
                            else if (at_end)
                            begin
                                mode_reg <= M_PASS;
                            end
                        end
                        else if (in_table && off_match)
                        begin
                            mode_reg <= M_DEL;
                        end
                        else if (at_end)
                        begin
                            mode_reg <= M_PASS;
                        end
                    end
                    if (last_step)
                    begin
                        state_reg <= S_DONE;
                        if (mode_reg == M_INS ||
                            (mode_reg == M_SCAN && op_reg == ffba_pkg::OP_ALLOC &&
                             at_end && end_fits))
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else if (mode_reg == M_DEL ||
                                 (mode_reg == M_SCAN && op_reg == ffba_pkg::OP_FREE &&
                                  in_table && off_match))
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg    <= s_tuser[0];
            bytes_reg <= s_tuser[1];
            size_reg  <= s_tdata[ffba_pkg::SIZE_W-1:0];
            off_reg   <= s_tdata[ffba_pkg::SIZE_W +: ffba_pkg::OFFSET_W];
        end
        if (state_reg == S_PREP)
        begin
            blk_reg      <= LEN_W'(req_blk);
            prev_end_reg <= '0;
            res_off_reg  <= '0;
            if (op_reg == ffba_pkg::OP_ALLOC)
            begin
                if (req_blk > NUM_W'(HEAP_BLOCKS))
                begin
                    status_reg <= ffba_pkg::ST_NO_SPACE;
                end
                else if (cnt_reg >= CNT_W'(MAX_FRAGMENTS))
                begin
                    status_reg <= ffba_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    status_reg <= ffba_pkg::ST_NO_SPACE;
                end
            end
            else
            begin
                status_reg <= ffba_pkg::ST_NOT_FOUND;
            end
        end
        if (state_reg == S_ROT)
        begin
            hold_reg <= cell_q[0];
            if (mode_reg == M_SCAN)
            begin
                if (op_reg == ffba_pkg::OP_ALLOC)
                begin
                    if ((in_table && gap_fits) || (at_end && end_fits))
                    begin
                        status_reg  <= ffba_pkg::ST_OK;
                        res_off_reg <= pay16(prev_end_reg[ADDR_W-1:0]);
                    end
                    else if (in_table)
                    begin
                        prev_end_reg <= h_start_ext + h_len;
                    end
                end
                else if (in_table && off_match)
                begin
                    status_reg  <= ffba_pkg::ST_OK;
                    res_off_reg <= off_reg;
                end
            end
        end
        if (out_load)
        begin
            m_data_reg <= ffba_pkg::M_TDATA_W'({res_off_reg, status_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FRAGMENTS))
        else $error("fragment count beyond table depth");

    a_cnt_only_at_turn_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(state_reg) == S_ROT && state_reg == S_DONE))
        else $error("fragment count moved outside the end of a table turn");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE && state_reg == S_IDLE))
        else $error("result raised without a finished request");

    a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && status_reg != ffba_pkg::ST_OK) |-> (res_off_reg == '0))
        else $error("failed request carries a nonzero offset");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |=> !s_fire)
        else $error("request taken while the table turns");

endmodule
